>>> rtl/lbs_pkg.sv
// Shared types and constants for the link bring-up sequencer.
// No dependencies; used by lbs_ctrl, lbs_datapath and the top level.
`timescale 1ns / 1ps

package lbs_pkg;

    // highest metadata port sent during the meta phase
    localparam logic [6:0] PORT_MAX = 7'd31;

    localparam int IN_W  = 24;
    localparam int OUT_W = 48;

    // link phases
    localparam logic [2:0] PH_DISC = 3'd0;
    localparam logic [2:0] PH_NEG  = 3'd1;
    localparam logic [2:0] PH_TS1  = 3'd2;
    localparam logic [2:0] PH_TS2  = 3'd3;
    localparam logic [2:0] PH_META = 3'd4;
    localparam logic [2:0] PH_CONN = 3'd5;

    // event codes
    localparam logic [3:0] ACT_DISCONNECT = 4'd0;
    localparam logic [3:0] ACT_CONNECT    = 4'd1;
    localparam logic [3:0] ACT_RESET_REQ  = 4'd2;
    localparam logic [3:0] ACT_TIMEOUT    = 4'd3;
    localparam logic [3:0] ACT_TICK       = 4'd4;
    localparam logic [3:0] ACT_NEG_DONE   = 4'd5;
    localparam logic [3:0] ACT_TS_DONE    = 4'd6;
    localparam logic [3:0] ACT_META_RSP   = 4'd7;
    localparam logic [3:0] ACT_RESET      = 4'd8;

    // frame kinds
    localparam logic [1:0] FK_NONE = 2'd0;
    localparam logic [1:0] FK_NEG  = 2'd1;
    localparam logic [1:0] FK_TS   = 2'd2;
    localparam logic [1:0] FK_META = 2'd3;

    // timer commands
    localparam logic [1:0] CMD_KEEP   = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_ARM    = 2'd2;

    localparam logic [11:0] TMO_DISC_MS = 12'd2500;
    localparam logic [11:0] TMO_LINK_MS = 12'd1000;

    localparam logic [13:0] TCK_NEG_MS   = 14'd50;
    localparam logic [13:0] TCK_RETRY_MS = 14'd2;
    localparam logic [13:0] TCK_META_MS  = 14'd1;
    localparam logic [13:0] TCK_SYNC_MS  = 14'd10000;
    localparam logic [13:0] TCK_SLOW_MS  = 14'd1000;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       load_frame;
        logic [1:0] frame_kind;
        logic       load_final;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] action;
        logic [2:0] phase;
        logic       server_mode;
        logic       credit_zero;
        logic       ports_done;
        logic       slot_free;
    } t_dp_stat;

endpackage

>>> rtl/lbs_ctrl.sv
// Controller state machine of the link bring-up sequencer.
// Depends on lbs_pkg; drives lbs_datapath through t_dp_cmd.
`timescale 1ns / 1ps

module lbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lbs_pkg::t_dp_stat i_stat,
    output lbs_pkg::t_dp_cmd  o_cmd
);
    import lbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_BURST,
        S_FRAME,
        S_FINAL
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FINAL;
                if (i_stat.action == ACT_TICK) begin
                    if (i_stat.phase == PH_META) begin
                        if (!i_stat.server_mode) n_state = S_BURST;
                    end else if (i_stat.phase == PH_NEG) begin
                        if (!i_stat.credit_zero) begin
                            n_kind  = FK_NEG;
                            n_state = S_FRAME;
                        end
                    end else if ((i_stat.phase == PH_TS1 || i_stat.phase == PH_TS2 ||
                                  i_stat.phase == PH_CONN) &&
                                 !i_stat.server_mode && !i_stat.credit_zero) begin
                        n_kind  = FK_TS;
                        n_state = S_FRAME;
                    end
                end
            end
            S_BURST: begin
                // one metadata record per free output slot until ports or credit run out
                if (i_stat.ports_done || i_stat.credit_zero) begin
                    n_state = S_FINAL;
                end else if (i_stat.slot_free) begin
                    o_cmd.load_frame = 1'b1;
                    o_cmd.frame_kind = FK_META;
                end
            end
            S_FRAME: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_frame = 1'b1;
                    o_cmd.frame_kind = r_kind;
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (i_stat.slot_free) begin
                    o_cmd.load_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= FK_NONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

>>> rtl/lbs_datapath.sv
// Datapath of the link bring-up sequencer: event latch, link state, credit
// counter, final-result decode and the output register. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    input  logic [lbs_pkg::IN_W-1:0]    i_req_data,
    input  lbs_pkg::t_dp_cmd            i_cmd,
    output lbs_pkg::t_dp_stat           o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lbs_pkg::OUT_W-1:0]   o_out_data,
    output logic                        o_out_last
);
    import lbs_pkg::*;

    logic              r_server_mode;
    logic [2:0]        r_phase;
    logic [6:0]        r_next_port;
    logic [3:0]        r_action;
    logic [5:0]        r_credit;
    logic              r_had_credit;
    logic [7:0]        r_meta_port;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_last;

    logic              slot_free;
    logic [2:0]        n_phase;
    logic [6:0]        n_port;
    logic [6:0]        rsp_port;
    logic              enter;
    logic [2:0]        tgt;
    logic [1:0]        tmo_cmd;
    logic [11:0]       tmo_ms;
    logic [1:0]        tck_cmd;
    logic [13:0]       tck_ms;
    logic              rep_flag;
    logic              rst_flag;
    logic [OUT_W-1:0]  final_data;
    logic [OUT_W-1:0]  frame_data;
    logic [5:0]        frame_port;

    assign slot_free = !r_out_valid || i_out_ready;

    assign o_stat.action      = r_action;
    assign o_stat.phase       = r_phase;
    assign o_stat.server_mode = r_server_mode;
    assign o_stat.credit_zero = (r_credit == 6'd0);
    assign o_stat.ports_done  = (r_next_port > PORT_MAX);
    assign o_stat.slot_free   = slot_free;

    // net effect of the event on phase, timers and flags
    always_comb begin
        n_phase  = r_phase;
        n_port   = r_next_port;
        enter    = 1'b0;
        tgt      = PH_DISC;
        tmo_cmd  = CMD_KEEP;
        tmo_ms   = '0;
        tck_cmd  = CMD_KEEP;
        tck_ms   = '0;
        rep_flag = 1'b0;
        rst_flag = 1'b0;
        rsp_port = r_next_port;
        if ({1'b0, r_next_port} <= r_meta_port) rsp_port = r_meta_port[6:0] + 7'd1;

        case (r_action)
            ACT_DISCONNECT, ACT_RESET: begin
                enter = 1'b1;
                tgt   = PH_DISC;
            end
            ACT_CONNECT: begin
                if (r_phase == PH_DISC) begin
                    enter = 1'b1;
                    tgt   = PH_NEG;
                end
            end
            ACT_RESET_REQ: begin
                if (r_phase != PH_DISC && r_phase != PH_NEG) begin
                    enter = 1'b1;
                    tgt   = PH_DISC;
                end
            end
            ACT_TIMEOUT: begin
                if (r_phase == PH_DISC) begin
                    tmo_cmd  = CMD_ARM;
                    tmo_ms   = TMO_DISC_MS;
                    rst_flag = 1'b1;
                end else begin
                    enter = 1'b1;
                    tgt   = PH_DISC;
                end
            end
            ACT_TICK: begin
                case (r_phase)
                    PH_META: begin
                        if (!r_server_mode) begin
                            if (r_next_port > PORT_MAX) begin
                                enter = 1'b1;
                                tgt   = PH_CONN;
                            end else begin
                                tck_cmd = CMD_ARM;
                                tck_ms  = TCK_META_MS;
                            end
                        end
                    end
                    PH_NEG: begin
                        if (!r_had_credit) begin
                            tck_cmd = CMD_ARM;
                            tck_ms  = TCK_RETRY_MS;
                        end
                    end
                    PH_TS1, PH_TS2: begin
                        tck_cmd = r_server_mode ? CMD_CANCEL : CMD_ARM;
                        if (!r_server_mode) tck_ms = r_had_credit ? TCK_NEG_MS : TCK_RETRY_MS;
                    end
                    PH_CONN: begin
                        tck_cmd = r_server_mode ? CMD_CANCEL : CMD_ARM;
                        if (!r_server_mode) tck_ms = r_had_credit ? TCK_SYNC_MS : TCK_SLOW_MS;
                    end
                    default: ;
                endcase
            end
            ACT_NEG_DONE: begin
                if (r_phase == PH_NEG) begin
                    enter = 1'b1;
                    tgt   = r_server_mode ? PH_META : PH_TS1;
                end
            end
            ACT_TS_DONE: begin
                if (r_phase == PH_TS1) begin
                    enter = 1'b1;
                    tgt   = PH_TS2;
                end else if (r_phase == PH_TS2) begin
                    enter = 1'b1;
                    tgt   = PH_META;
                end
            end
            ACT_META_RSP: begin
                if (r_phase == PH_META && r_meta_port <= {1'b0, PORT_MAX}) begin
                    n_port = rsp_port;
                    if (rsp_port > PORT_MAX) begin
                        enter = 1'b1;
                        tgt   = PH_CONN;
                    end
                end
            end
            default: ;
        endcase

        // phase entry overrides what the event set before it
        if (enter) begin
            n_phase = tgt;
            case (tgt)
                PH_DISC: begin
                    tmo_cmd  = CMD_ARM;
                    tmo_ms   = TMO_DISC_MS;
                    tck_cmd  = CMD_CANCEL;
                    tck_ms   = '0;
                    rep_flag = 1'b1;
                    rst_flag = 1'b1;
                end
                PH_NEG: begin
                    tmo_cmd = CMD_ARM;
                    tmo_ms  = TMO_LINK_MS;
                    if (r_server_mode) begin
                        tck_cmd = CMD_ARM;
                        tck_ms  = TCK_NEG_MS;
                    end
                end
                PH_TS1, PH_TS2: begin
                    tmo_cmd = CMD_ARM;
                    tmo_ms  = TMO_LINK_MS;
                    tck_cmd = r_server_mode ? CMD_CANCEL : CMD_ARM;
                    tck_ms  = r_server_mode ? 14'd0 : TCK_RETRY_MS;
                end
                PH_META: begin
                    tmo_cmd = CMD_ARM;
                    tmo_ms  = TMO_LINK_MS;
                    tck_cmd = CMD_ARM;
                    tck_ms  = TCK_META_MS;
                    n_port  = '0;
                end
                default: begin
                    tmo_cmd  = CMD_CANCEL;
                    tmo_ms   = '0;
                    tck_cmd  = r_server_mode ? CMD_CANCEL : CMD_ARM;
                    tck_ms   = r_server_mode ? 14'd0 : TCK_META_MS;
                    rep_flag = 1'b1;
                end
            endcase
        end
    end

    assign final_data = {5'd0, rst_flag, rep_flag, tck_ms, tck_cmd, tmo_ms, tmo_cmd,
                         n_phase, 6'd0, FK_NONE};
    assign frame_port = (i_cmd.frame_kind == FK_META) ? r_next_port[5:0] : 6'd0;
    assign frame_data = {40'd0, frame_port, i_cmd.frame_kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_mode <= 1'b0;
            r_phase       <= PH_DISC;
            r_next_port   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_server_mode <= i_cfg_wr_data;
            if (i_cmd.load_frame && i_cmd.frame_kind == FK_META)
                r_next_port <= r_next_port + 7'd1;
            if (i_cmd.load_final) begin
                r_phase     <= n_phase;
                r_next_port <= n_port;
            end
            if (i_cmd.load_frame || i_cmd.load_final) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action     <= i_req_data[3:0];
            r_credit     <= i_req_data[9:4];
            r_had_credit <= |i_req_data[9:4];
            r_meta_port  <= i_req_data[17:10];
        end else if (i_cmd.load_frame) begin
            r_credit <= r_credit - 6'd1;
        end
        if (i_cmd.load_frame) begin
            r_out_data <= frame_data;
            r_out_last <= 1'b0;
        end else if (i_cmd.load_final) begin
            r_out_data <= final_data;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load_frame && i_cmd.load_final))
        else $error("frame and final loaded together");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(i_cmd.load_frame || i_cmd.load_final))
        else $error("pending result overwritten");

    a_record_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_frame && i_cmd.frame_kind == FK_META) |->
            (r_credit != 6'd0 && r_next_port <= PORT_MAX && r_phase == PH_META))
        else $error("metadata record without credit or past last port");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_CONN)
        else $error("link phase out of range");

    a_phase_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.load_final && !i_cfg_wr_en) |=> $stable(r_phase))
        else $error("phase changed outside final result");

endmodule

>>> rtl/link_bringup_sequencer.sv
// Top level of the link bring-up sequencer: stream ports and config register.
// Depends on lbs_pkg, lbs_ctrl and lbs_datapath.
`timescale 1ns / 1ps

// Link bring-up controller for one endpoint. Each accepted request is one event;
// the block answers with zero or more frame results and then one final result
// (tlast high) carrying the new link state, timer commands and flags. An event
// sends no frame, one negotiate or timesync request, or, for a tick in the meta
// phase of a client, N metadata records (N may be 0, at most PORT_MAX + 1). The
// controller emits one result per cycle through the single output register
// while the master side takes them, holds while that register is still full,
// and ends the burst in a state that emits nothing. A new request is taken
// while the final result of the previous one still waits on the master side.
// server_mode is written through i_cfg_wr_en / i_cfg_wr_data; the user must write
// it only while no event is in progress, the block itself does not enforce this.
module link_bringup_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] action, [9:4] tx_credit, [17:10] meta_port, [23:18] zero
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] frame_kind, [7:2] frame_port, [10:8] link_state, [12:11] timeout_cmd,
    // [24:13] timeout delay, [26:25] tick_cmd, [40:27] tick_ms, [41] state_report,
    // [42] link_reset, [47:43] zero
    output logic [47:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import lbs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lbs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_data    (i_s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata),
        .o_out_last    (o_m_axis_tlast)
    );

endmodule

>>> tb/tb.sv
// Self-checking bench for link_bringup_sequencer: stream driver and monitor with random
// gaps and stalls, results checked against an event-level model of the bring-up FSM.
// Depends on lbs_pkg and the link_bringup_sequencer RTL.
`timescale 1ns / 1ps

module tb;
    import lbs_pkg::*;

    // action codes the block does not define
    localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

    // one answer of the block, laid out as {tlast, tdata}
    typedef struct packed {
        logic        last;
        logic [4:0]  pad;
        logic        link_rst;
        logic        report;
        logic [13:0] tck_ms;
        logic [1:0]  tck_cmd;
        logic [11:0] tmo_ms;
        logic [1:0]  tmo_cmd;
        logic [2:0]  state;
        logic [5:0]  port;
        logic [1:0]  kind;
    } result_t;

    typedef struct packed {
        logic [3:0] action;
        logic [5:0] credit;
        logic [7:0] mport;
    } event_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [23:0] i_s_axis_tdata = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    link_bringup_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- model
    logic [2:0]  lp_phase = PH_DISC;
    logic [6:0]  lp_next_port = '0;
    logic        lp_server = 1'b0;

    int unsigned ev_credit;
    logic [1:0]  ev_tmo_cmd, ev_tck_cmd;
    logic [11:0] ev_tmo_ms;
    logic [13:0] ev_tck_ms;
    logic        ev_report, ev_reset;

    result_t     due_results[$];
    event_t      event_q[$];

    int errors = 0;
    int events_sent = 0;
    int results_seen = 0;
    int meta_frames = 0;
    int queued = 0;
    int conn_hits[2] = '{0, 0};
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    function automatic void arm_timeout(logic [11:0] ms);
        ev_tmo_cmd = CMD_ARM;
        ev_tmo_ms  = ms;
    endfunction

    function automatic void cancel_timeout();
        ev_tmo_cmd = CMD_CANCEL;
        ev_tmo_ms  = '0;
    endfunction

    function automatic void arm_tick(logic [13:0] ms);
        ev_tck_cmd = CMD_ARM;
        ev_tck_ms  = ms;
    endfunction

    function automatic void cancel_tick();
        ev_tck_cmd = CMD_CANCEL;
        ev_tck_ms  = '0;
    endfunction

    function automatic bit send_frame(logic [1:0] kind, logic [5:0] port);
        result_t r;
        if (ev_credit == 0) return 1'b0;
        ev_credit--;
        r      = '0;
        r.kind = kind;
        r.port = port;
        due_results.push_back(r);
        return 1'b1;
    endfunction

    function automatic void enter_phase(logic [2:0] ph);
        lp_phase = ph;
        case (ph)
            PH_DISC: begin
                arm_timeout(TMO_DISC_MS);
                cancel_tick();
                ev_report = 1'b1;
                ev_reset  = 1'b1;
            end
            PH_NEG: begin
                arm_timeout(TMO_LINK_MS);
                if (lp_server) arm_tick(TCK_NEG_MS);
            end
            PH_TS1, PH_TS2: begin
                cancel_tick();
                arm_timeout(TMO_LINK_MS);
                if (!lp_server) arm_tick(TCK_RETRY_MS);
            end
            PH_META: begin
                arm_timeout(TMO_LINK_MS);
                lp_next_port = '0;
                arm_tick(TCK_META_MS);
            end
            default: begin
                cancel_timeout();
                cancel_tick();
                if (!lp_server) arm_tick(TCK_META_MS);
                ev_report = 1'b1;
                conn_hits[lp_server]++;
            end
        endcase
    endfunction

    // burst of metadata records until ports or credit run out; 1 when all ports went out
    function automatic bit meta_tick();
        if (lp_server) return 1'b0;
        while (lp_next_port <= PORT_MAX) begin
            if (!send_frame(FK_META, lp_next_port[5:0])) begin
                arm_tick(TCK_META_MS);
                return 1'b0;
            end
            lp_next_port++;
        end
        return 1'b1;
    endfunction

    function automatic void link_tick();
        case (lp_phase)
            PH_NEG: begin
                if (!send_frame(FK_NEG, '0)) arm_tick(TCK_RETRY_MS);
            end
            PH_TS1, PH_TS2: begin
                cancel_tick();
                if (!lp_server) begin
                    if (send_frame(FK_TS, '0)) arm_tick(TCK_NEG_MS);
                    else arm_tick(TCK_RETRY_MS);
                end
            end
            PH_CONN: begin
                cancel_tick();
                if (!lp_server) begin
                    if (send_frame(FK_TS, '0)) arm_tick(TCK_SYNC_MS);
                    else arm_tick(TCK_SLOW_MS);
                end
            end
            default: ;
        endcase
    endfunction

    // one event: queues the frames it sends and then its final result
    function automatic void bringup_step(event_t ev);
        result_t fin;
        bit      done;
        done       = 1'b0;
        ev_credit  = ev.credit;
        ev_tmo_cmd = CMD_KEEP;
        ev_tmo_ms  = '0;
        ev_tck_cmd = CMD_KEEP;
        ev_tck_ms  = '0;
        ev_report  = 1'b0;
        ev_reset   = 1'b0;
        case (ev.action)
            ACT_DISCONNECT, ACT_RESET: enter_phase(PH_DISC);
            ACT_CONNECT: begin
                if (lp_phase == PH_DISC) enter_phase(PH_NEG);
            end
            ACT_RESET_REQ: begin
                if (lp_phase != PH_DISC && lp_phase != PH_NEG) enter_phase(PH_DISC);
            end
            ACT_TIMEOUT: begin
                if (lp_phase == PH_DISC) begin
                    arm_timeout(TMO_DISC_MS);
                    ev_reset = 1'b1;
                end else begin
                    enter_phase(PH_DISC);
                end
            end
            ACT_TICK: begin
                if (lp_phase == PH_META) done = meta_tick();
                else link_tick();
            end
            ACT_NEG_DONE: begin
                if (lp_phase == PH_NEG) enter_phase(lp_server ? PH_META : PH_TS1);
            end
            ACT_TS_DONE: begin
                if (lp_phase == PH_TS1) enter_phase(PH_TS2);
                else if (lp_phase == PH_TS2) enter_phase(PH_META);
            end
            ACT_META_RSP: begin
                if (lp_phase == PH_META && ev.mport <= PORT_MAX) begin
                    if (ev.mport >= lp_next_port) lp_next_port = ev.mport[6:0] + 7'd1;
                    if (lp_next_port > PORT_MAX) done = 1'b1;
                end
            end
            default: ;
        endcase
        if (done && lp_phase == PH_META) enter_phase(PH_CONN);

        fin          = '0;
        fin.state    = lp_phase;
        fin.tmo_cmd  = ev_tmo_cmd;
        fin.tmo_ms   = ev_tmo_ms;
        fin.tck_cmd  = ev_tck_cmd;
        fin.tck_ms   = ev_tck_ms;
        fin.report   = ev_report;
        fin.link_rst = ev_reset;
        fin.last     = 1'b1;
        due_results.push_back(fin);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    function automatic int pick_gap();
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_credit();
        int p;
        p = $urandom_range(99);
        if (p < 10) return 0;
        if (p < 70) return $urandom_range(1, 8);
        return $urandom_range(9, 63);
    endfunction

    function automatic int rand_meta_port();
        int p;
        p = $urandom_range(99);
        if (p < 15) return PORT_MAX;
        if (p < 85) return $urandom_range(PORT_MAX);
        return $urandom_range(255);
    endfunction

    function automatic void push_ev(int action, int credit, int mport);
        event_t e;
        e.action = action[3:0];
        e.credit = credit[5:0];
        e.mport  = mport[7:0];
        event_q.push_back(e);
        queued++;
    endfunction

    function automatic void push_abort();
        case ($urandom_range(3))
            0: push_ev(ACT_TIMEOUT, $urandom, $urandom);
            1: push_ev(ACT_RESET_REQ, $urandom, $urandom);
            2: push_ev(ACT_DISCONNECT, $urandom, $urandom);
            default: push_ev(ACT_RESET, $urandom, $urandom);
        endcase
    endfunction

    // occasional noise request, and sometimes the sequence is cut short
    function automatic bit bail();
        if ($urandom_range(99) < 8) push_ev($urandom_range(15), $urandom, $urandom);
        if ($urandom_range(99) < 6) begin
            push_abort();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one bring-up from a dropped link towards connected, random content
    function automatic void push_bringup(bit srv);
        push_ev($urandom_range(1) ? ACT_DISCONNECT : ACT_RESET, $urandom, $urandom);
        push_ev(ACT_CONNECT, $urandom, $urandom);
        repeat ($urandom_range(2)) push_ev(ACT_TICK, rand_credit(), $urandom);
        if (bail()) return;
        push_ev(ACT_NEG_DONE, $urandom, $urandom);
        if (!srv) begin
            repeat (2) begin
                repeat ($urandom_range(2)) push_ev(ACT_TICK, rand_credit(), $urandom);
                push_ev(ACT_TS_DONE, $urandom, $urandom);
            end
            if (bail()) return;
        end
        repeat ($urandom_range(1, 6)) begin
            if (srv || $urandom_range(2) == 0)
                push_ev(ACT_META_RSP, $urandom, rand_meta_port());
            else
                push_ev(ACT_TICK, rand_credit(), $urandom);
        end
        if (bail()) return;
        repeat ($urandom_range(3)) push_ev(ACT_TICK, rand_credit(), $urandom);
        push_abort();
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (event_q.size() != 0 || i_s_axis_tvalid || due_results.size() != 0);
    endtask

    task automatic write_mode(bit srv);
        wait_drained();
        repeat (6) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= srv;
        lp_server = srv;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(bit srv, int n, int src_pct, int snk_pct);
        write_mode(srv);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        queued = 0;
        while (queued < n) push_bringup(srv);
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // ---------------------------------------------------------------- request driver
    event_t in_flight;
    int     src_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                bringup_step(in_flight);
                events_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    in_flight = event_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {6'd0, in_flight.mport, in_flight.credit, in_flight.action};
                    if ($urandom_range(99) < src_idle_pct) src_gap = pick_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    int snk_stall = 0;

    always @(posedge i_clk) begin
        result_t got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tlast, o_m_axis_tdata};
                results_seen++;
                if (got.kind == FK_META) meta_frames++;
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with nothing due, expected none, actual %h",
                             $time, got);
                end else begin
                    want = due_results.pop_front();
                    check_field("frame_kind", want.kind, got.kind);
                    check_field("frame_port", want.port, got.port);
                    check_field("link_state", want.state, got.state);
                    check_field("timeout_cmd", want.tmo_cmd, got.tmo_cmd);
                    check_field("tmo_delay_ms", want.tmo_ms, got.tmo_ms);
                    check_field("tick_cmd", want.tck_cmd, got.tck_cmd);
                    check_field("tick_ms", want.tck_ms, got.tck_ms);
                    check_field("state_report", want.report, got.report);
                    check_field("link_reset", want.link_rst, got.link_rst);
                    check_field("pad bits", want.pad, got.pad);
                    check_field("tlast", want.last, got.last);
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(99) < snk_idle_pct) begin
                snk_stall = pick_gap() - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed client walk, no idling
        write_mode(1'b0);
        push_ev(ACT_TIMEOUT, 63, 255);      // timeout while disconnected
        push_ev(ACT_RESET_REQ, 0, 0);       // ignored while disconnected
        push_ev(ACT_TICK, 0, 0);            // no meaning here
        push_ev(ACT_META_RSP, 63, 5);       // outside meta
        push_ev(ACT_UNUSED_LO, 9, 31);
        push_ev(ACT_UNUSED_HI, 42, 170);
        push_ev(ACT_DISCONNECT, 1, 0);      // re-entry of disconnected
        push_ev(ACT_RESET, 0, 128);
        push_ev(ACT_CONNECT, 21, 85);
        push_ev(ACT_RESET_REQ, 5, 0);       // ignored while negotiating
        push_ev(ACT_TICK, 0, 0);            // failed negotiate send
        push_ev(ACT_TICK, 1, 0);
        push_ev(ACT_NEG_DONE, 7, 0);
        push_ev(ACT_TICK, 0, 0);            // failed timesync send
        push_ev(ACT_TICK, 2, 0);
        push_ev(ACT_TS_DONE, 0, 0);
        push_ev(ACT_TICK, 1, 0);
        push_ev(ACT_TS_DONE, 0, 0);
        push_ev(ACT_TICK, 3, 0);            // burst cut by credit
        push_ev(ACT_META_RSP, 0, 255);      // port above the limit
        push_ev(ACT_META_RSP, 0, 10);
        push_ev(ACT_META_RSP, 0, 4);        // below the next port
        push_ev(ACT_TICK, 63, 0);           // rest of the ports, then connected
        push_ev(ACT_TICK, 0, 0);            // failed sync send once connected
        push_ev(ACT_TICK, 1, 0);
        push_ev(ACT_RESET_REQ, 0, 0);

        // server side: directed walk then random bring-ups
        write_mode(1'b1);
        push_ev(ACT_CONNECT, 0, 0);
        push_ev(ACT_TICK, 0, 0);
        push_ev(ACT_NEG_DONE, 0, 0);
        push_ev(ACT_TICK, 63, 0);           // server meta tick sends nothing
        push_ev(ACT_META_RSP, 0, PORT_MAX);
        push_ev(ACT_TICK, 63, 0);
        push_ev(ACT_TIMEOUT, 0, 0);
        src_idle_pct = 40;
        snk_idle_pct = 10;
        queued = 0;
        while (queued < 110) push_bringup(1'b1);

        run_random(1'b0, 130, 25, 25);
        run_random(1'b1, 35, 0, 0);
        run_random(1'b0, 100, 10, 45);

        wait_drained();
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        if (due_results.size() != 0) begin
            errors++;
            $display("%0t ns: %0d results still due at the end", $time, due_results.size());
        end
        $display("Ran %0d events in client and server mode, %0d results with %0d metadata records.",
                 events_sent, results_seen, meta_frames);
        $display("Connected reached %0d times as client, %0d as server; %0d mismatches.",
                 conn_hits[0], conn_hits[1], errors);
        if (errors == 0) begin
            $display("link_bringup_sequencer test passed");
        end else begin
            $display("link_bringup_sequencer test failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("%0t ns: timeout, %0d results still due", $time, due_results.size());
        $display("link_bringup_sequencer test failed");
        $finish;
    end

endmodule
